FILE: hdl/keyed_saturating_counter_table_assert.svh
// Assertion macros used by the keyed saturating counter table RTL
`ifndef KEYED_SATURATING_COUNTER_TABLE_ASSERT_SVH
`define KEYED_SATURATING_COUNTER_TABLE_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define KSCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define KSCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ksct_pkg.sv
// Package with types and constants of the keyed saturating counter table
`timescale 1ns / 1ps

package ksct_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Field widths
  localparam int KEY_W    = 8;
  localparam int AMOUNT_W = 24;
  localparam int CHANGE_W = 25;
  localparam int POS_W    = 4;
  localparam int USED_W   = 5;

  localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = 24'hff_ffff;

  // Request codes
  localparam logic REQ_MODIFY = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [KEY_W-1:0]    class_key;
    logic [CHANGE_W-1:0] change;
  } ksct_in_t;

  typedef struct packed {
    logic [AMOUNT_W-1:0] amount;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [USED_W-1:0]   entries_used;
    logic                table_full;
  } ksct_out_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [AMOUNT_W-1:0] amount;
  } entry_t;

  // Per-cell update operation
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_FROM_LEFT,
    OP_FROM_RIGHT,
    OP_SET_AMOUNT
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [AMOUNT_W-1:0] amount;
  } cell_ctrl_t;

endpackage

FILE: hdl/ksct_cell.sv
// One table cell: holds an entry, joins the search chain, shifts with its neighbors
`timescale 1ns / 1ps

module ksct_cell
  import ksct_pkg::*;
(
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic                valid_i,
  input  logic [KEY_W-1:0]    cmp_key,
  input  logic                hit_i,
  output logic                hit_o,
  input  logic [AMOUNT_W-1:0] sel_i,
  output logic [AMOUNT_W-1:0] sel_o,
  output logic                first_o,
  input  entry_t              left_i,
  input  entry_t              right_i,
  output entry_t              entry_o
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   match;

  // Compare against the key and pass the first hit down the chain
  assign match   = valid_i && (entry_r.key == cmp_key);
  assign first_o = match && !hit_i;
  assign hit_o   = hit_i || match;
  assign sel_o   = sel_i | (first_o ? entry_r.amount : '0);
  assign entry_o = entry_r;

  // Select the next entry
  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      OP_FROM_LEFT:  entry_nxt = left_i;
      OP_FROM_RIGHT: entry_nxt = right_i;
      OP_SET_AMOUNT: entry_nxt.amount = ctrl.amount;
      default:       entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

FILE: hdl/keyed_saturating_counter_table.sv
// Top level of the keyed saturating counter table
// Usage:
//   Requests enter on in_data with in_valid/in_stall; a transfer happens on a
//   clock edge with in_valid high and in_stall low. Each request yields exactly
//   one result on out_data with out_valid/out_stall.
//   A modify request adds a clamped signed change to the entry with the given
//   key (inserting it at the front when missing and the table is not full,
//   removing it when it reaches zero); a lookup returns the current amount or zero.
// Search and update:
//   The key search across the chain of cells runs in the transfer cycle; the
//   search result is registered, and the saturating add and the table shift
//   follow in the update state, when the result is written to the output
//   register. in_stall is high in the update state, so a new request is taken
//   only once the last one has left the search stage and the single update stage.
// Reset:
//   rst_n clears the state, the entry count and the output valid flag; entry contents are
//   not cleared, since only entries below the count are ever searched.
// Stall:
//   While out_stall holds a result, one more request may be taken and searched;
//   its update waits until the output register is free, and in_stall stays high.
`timescale 1ns / 1ps

module keyed_saturating_counter_table
  import ksct_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ksct_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ksct_out_t out_data
);

  `include "keyed_saturating_counter_table_assert.svh"

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  ksct_out_t           out_r;
  ksct_out_t           out_nxt;

  ksct_in_t            req_r;
  logic                found_r;
  logic [IDX_W-1:0]    pos_r;
  logic [AMOUNT_W-1:0] cur_r;

  logic                in_xfer;
  logic                out_free;
  logic                do_update;

  logic                hit   [TABLE_ENTRIES+1];
  logic [AMOUNT_W-1:0] sel   [TABLE_ENTRIES+1];
  logic                first [TABLE_ENTRIES];
  entry_t              entry [TABLE_ENTRIES];
  cell_ctrl_t          ctrl  [TABLE_ENTRIES];
  logic [IDX_W-1:0]    pos_enc;

  logic signed [CHANGE_W-1:0] chg_clamped;
  logic signed [CHANGE_W:0]   sum;
  logic [AMOUNT_W-1:0]        new_amount;
  logic                       is_modify;
  logic                       do_insert;
  logic                       do_remove;
  logic                       refused;
  entry_t                     new_entry;

  // Handshake
  assign in_stall  = (state_r == ST_UPDATE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign do_update = (state_r == ST_UPDATE) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Chain of cells
  assign hit[0] = 1'b0;
  assign sel[0] = '0;
  assign new_entry.key    = req_r.class_key;
  assign new_entry.amount = new_amount;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    if (i == 0) begin : g_head
      assign left_e = new_entry;
    end else begin : g_body
      assign left_e = entry[i-1];
    end
    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entry[i+1];
    end

    ksct_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl[i]),
      .valid_i (CNT_W'(i) < count_r),
      .cmp_key (in_data.class_key),
      .hit_i   (hit[i]),
      .hit_o   (hit[i+1]),
      .sel_i   (sel[i]),
      .sel_o   (sel[i+1]),
      .first_o (first[i]),
      .left_i  (left_e),
      .right_i (right_e),
      .entry_o (entry[i])
    );
  end

  // Encode the position of the first hit
  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (first[i]) begin
        pos_enc = pos_enc | IDX_W'(i);
      end
    end
  end

  // Capture search results on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r   <= in_data;
      found_r <= hit[TABLE_ENTRIES];
      pos_r   <= pos_enc;
      cur_r   <= sel[TABLE_ENTRIES];
    end
  end

  // Clamp the change, add and saturate
  always_comb begin
    chg_clamped = $signed(req_r.change);
    if (req_r.change == {1'b1, {(CHANGE_W-1){1'b0}}}) begin
      chg_clamped = -$signed({1'b0, AMOUNT_MAX});
    end
    sum = $signed({2'b00, cur_r}) + $signed({chg_clamped[CHANGE_W-1], chg_clamped});
    if (sum[CHANGE_W]) begin
      new_amount = '0;
    end else if (sum[CHANGE_W-1]) begin
      new_amount = AMOUNT_MAX;
    end else begin
      new_amount = sum[AMOUNT_W-1:0];
    end
  end

  // Decide the table operation
  assign is_modify = (req_r.req_type == REQ_MODIFY);
  assign refused   = is_modify && !found_r && (count_r >= CNT_W'(TABLE_ENTRIES));
  assign do_insert = is_modify && !found_r && !refused;
  assign do_remove = is_modify && found_r && (new_amount == '0);

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      ctrl[i].op     = OP_HOLD;
      ctrl[i].amount = new_amount;
      if (do_update && is_modify) begin
        if (do_insert) begin
          ctrl[i].op = OP_FROM_LEFT;
        end else if (do_remove) begin
          if (IDX_W'(i) >= pos_r) begin
            ctrl[i].op = OP_FROM_RIGHT;
          end
        end else if (found_r && (IDX_W'(i) == pos_r)) begin
          ctrl[i].op = OP_SET_AMOUNT;
        end
      end
    end
  end

  // Next count and result
  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
    out_nxt.amount       = is_modify ? new_amount : cur_r;
    out_nxt.found        = found_r;
    out_nxt.position     = found_r ? POS_W'(pos_r) : '0;
    out_nxt.entries_used = USED_W'(count_nxt);
    out_nxt.table_full   = refused;
  end

  // State, count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new result on update, drop the old one once it is taken
      if (do_update) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            count_r <= count_nxt;
            out_r   <= out_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Assertions
  `KSCT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(TABLE_ENTRIES),
    "entry count above table size")
  `KSCT_ASSERT_NOW(a_pos_valid, (state_r == ST_UPDATE) && found_r,
    CNT_W'(pos_r) < count_r, "hit position outside valid entries")
  `KSCT_ASSERT_NEXT(a_insert_count, do_update && do_insert,
    count_r == $past(count_r) + CNT_W'(1), "insert did not grow the count")
  `KSCT_ASSERT_NOW(a_full_result, out_valid_r && out_r.table_full,
    !out_r.found && (out_r.entries_used == USED_W'(TABLE_ENTRIES)),
    "refused insert with inconsistent result")

endmodule
